// ===== rtl/rpm_pkg.sv =====
// ============================================================================
// RCPC puncture position mapper - shared package
// Types, widths and mode codes used across the mapper pipeline.
// ============================================================================
`default_nettype none

package rpm_pkg;

  // Field widths.
  localparam int unsigned IndexW  = 12;
  localparam int unsigned CostW   = 16;
  localparam int unsigned PosW    = 13;
  localparam int unsigned KW      = 14;
  localparam int unsigned BlkW    = 11;
  localparam int unsigned TapIdxW = 5;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 2;

  // Largest coded index that is mapped.
  localparam int unsigned MaxIndex = 4095;

  // Saturation value for the mother position and reset of the length register.
  localparam logic [PosW-1:0] PosMax         = 13'd8191;
  localparam logic [PosW-1:0] MotherLenReset = 13'd432;

  // Puncturer selection codes.
  typedef enum logic [ModeW-1:0] {
    ModeR23  = 3'd0,
    ModeR13  = 3'd1,
    ModeR292 = 3'd2,
    ModeR148 = 3'd3,
    ModeR112 = 3'd4,
    ModeR72  = 3'd5,
    ModeR38  = 3'd6
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegMode      = 2'd0,
    RegMotherLen = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [IndexW-1:0] coded_index;
    logic [CostW-1:0]  soft_cost;
  } in_t;

  typedef struct packed {
    logic [PosW-1:0]  mother_position;
    logic             in_range;
    logic [CostW-1:0] cost_out;
  } out_t;

  // Hand-over from the stretch stage to the divider stages.
  typedef struct packed {
    logic                live;
    logic [IndexW-1:0]   jm1;
    logic [2*IndexW-1:0] prod;
    logic [CostW-1:0]    cost;
  } s1_t;

  // Hand-over from the divider stages to the mapping stages.
  typedef struct packed {
    logic               live;
    logic [BlkW-1:0]    blk;
    logic [TapIdxW-1:0] pos;
    logic [CostW-1:0]   cost;
  } s3_t;

endpackage : rpm_pkg

`default_nettype wire

// ===== rtl/rpm_stretch.sv =====
// ============================================================================
// RCPC puncture position mapper - index check and stretch multiply
// Qualifies the coded index and forms the reciprocal product for the
// index stretch of the two stretched modes.
// ============================================================================
`default_nettype none

module rpm_stretch
  import rpm_pkg::*;
#(
  parameter int unsigned MaxIdx = MaxIndex
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire logic             in_valid_i,
  input  wire in_t              in_item_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output s1_t                   out_item_o,
  input  wire logic             out_ready_i
);

  logic valid_q;
  s1_t  s1_d;
  s1_t  s1_q;

  // Reciprocals: floor(x/65) = (x*4033)>>18 and floor(x/35) = (x*3745)>>17
  // are exact for every 12-bit x.
  always_comb begin
    logic [IndexW-1:0] jm1;
    logic [IndexW-1:0] mul;
    jm1 = in_item_i.coded_index - IndexW'(1);
    case (mode_i)
      ModeR292: mul = 12'd4033;
      ModeR148: mul = 12'd3745;
      default:  mul = '0;
    endcase
    s1_d.live = (mode_i <= ModeR38) && (in_item_i.coded_index != '0) &&
                (32'(in_item_i.coded_index) <= MaxIdx);
    s1_d.jm1  = jm1;
    s1_d.prod = (2*IndexW)'(jm1) * (2*IndexW)'(mul);
    s1_d.cost = in_item_i.soft_cost;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

endmodule : rpm_stretch

`default_nettype wire

// ===== rtl/rpm_divide.sv =====
// ============================================================================
// RCPC puncture position mapper - block divider
// Adds the stretch quotient, then splits the index into block number and
// position within the block by reciprocal multiplication over two stages.
// ============================================================================
`default_nettype none

module rpm_divide
  import rpm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire logic             in_valid_i,
  input  wire s1_t              in_item_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output s3_t                   out_item_o,
  input  wire logic             out_ready_i
);

  localparam int unsigned ProdW = 28;

  typedef struct packed {
    logic             live;
    logic [PosW-1:0]  im1;
    logic [ProdW-1:0] prod;
    logic [CostW-1:0] cost;
  } s2_t;

  logic s2_valid_q;
  logic s3_valid_q;
  logic s2_ready;
  logic s3_ready;
  s2_t  s2_d;
  s2_t  s2_q;
  s3_t  s3_d;
  s3_t  s3_q;

  // Stage two: stretched index minus one, times the reciprocal of the
  // block length. The reciprocals are exact for all 13-bit dividends.
  always_comb begin
    logic [6:0]      quot;
    logic [PosW-1:0] im1;
    logic [13:0]     mul;
    case (mode_i)
      ModeR292: quot = {1'b0, in_item_i.prod[23:18]};
      ModeR148: quot = in_item_i.prod[23:17];
      default:  quot = '0;
    endcase
    im1 = PosW'(in_item_i.jm1) + PosW'(quot);
    case (mode_i)
      ModeR23, ModeR292, ModeR112, ModeR13, ModeR148: mul = 14'd10923;
      ModeR72:                                        mul = 14'd14564;
      ModeR38:                                        mul = 14'd15421;
      default:                                        mul = '0;
    endcase
    s2_d.live = in_item_i.live;
    s2_d.im1  = im1;
    s2_d.prod = ProdW'(im1) * ProdW'(mul);
    s2_d.cost = in_item_i.cost;
  end

  // Stage three: shift out the quotient and recover the remainder.
  always_comb begin
    logic [4:0]       shift;
    logic [4:0]       tlen;
    logic [ProdW-1:0] shifted;
    logic [BlkW-1:0]  blk;
    logic [15:0]      base;
    logic [PosW-1:0]  rem;
    case (mode_i)
      ModeR23, ModeR292, ModeR112: begin
        shift = 5'd15;
        tlen  = 5'd3;
      end
      ModeR13, ModeR148: begin
        shift = 5'd16;
        tlen  = 5'd6;
      end
      ModeR72: begin
        shift = 5'd17;
        tlen  = 5'd9;
      end
      ModeR38: begin
        shift = 5'd18;
        tlen  = 5'd17;
      end
      default: begin
        shift = '0;
        tlen  = '0;
      end
    endcase
    shifted   = s2_q.prod >> shift;
    blk       = shifted[BlkW-1:0];
    base      = 16'(blk) * 16'(tlen);
    rem       = s2_q.im1 - base[PosW-1:0];
    s3_d.live = s2_q.live;
    s3_d.blk  = blk;
    s3_d.pos  = rem[TapIdxW-1:0];
    s3_d.cost = s2_q.cost;
  end

  assign s3_ready    = !s3_valid_q || out_ready_i;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign in_ready_o  = s2_ready;
  assign out_valid_o = s3_valid_q;
  assign out_item_o  = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= in_valid_i;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && in_valid_i) begin
      s2_q <= s2_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

endmodule : rpm_divide

`default_nettype wire

// ===== rtl/rpm_map.sv =====
// ============================================================================
// RCPC puncture position mapper - position mapping and range check
// Forms the mother position from block and tap table, then saturates it and
// checks it against the mother length.
// ============================================================================
`default_nettype none

module rpm_map
  import rpm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire logic [PosW-1:0]  mlen_i,
  input  wire logic             in_valid_i,
  input  wire s3_t              in_item_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output out_t                  out_item_o,
  input  wire logic             out_ready_i
);

  typedef struct packed {
    logic             live;
    logic [KW-1:0]    k;
    logic [CostW-1:0] cost;
  } s4_t;

  // Tap tables, padded with zeros to a power of two.
  localparam logic [4:0] TapR23 [4] = '{5'd1, 5'd2, 5'd5, 5'd0};
  localparam logic [4:0] TapR13 [8] = '{5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd0, 5'd0};
  localparam logic [4:0] TapR112 [4] = '{5'd1, 5'd2, 5'd4, 5'd0};
  localparam logic [4:0] TapR72 [16] = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd7, 5'd8, 5'd10,
                                         5'd11, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
  localparam logic [4:0] TapR38 [32] = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd7, 5'd8, 5'd10,
                                         5'd11, 5'd13, 5'd14, 5'd16, 5'd17, 5'd19, 5'd20,
                                         5'd22, 5'd23, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
                                         5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
                                         5'd0};

  logic s4_valid_q;
  logic s5_valid_q;
  logic s4_ready;
  logic s5_ready;
  s4_t  s4_d;
  s4_t  s4_q;
  out_t s5_d;
  out_t s5_q;

  always_comb begin
    logic [4:0]  period;
    logic [4:0]  tap;
    logic [15:0] base;
    case (mode_i)
      ModeR23, ModeR292: begin
        period = 5'd8;
        tap    = TapR23[in_item_i.pos[1:0]];
      end
      ModeR13, ModeR148: begin
        period = 5'd8;
        tap    = TapR13[in_item_i.pos[2:0]];
      end
      ModeR112: begin
        period = 5'd6;
        tap    = TapR112[in_item_i.pos[1:0]];
      end
      ModeR72: begin
        period = 5'd12;
        tap    = TapR72[in_item_i.pos[3:0]];
      end
      ModeR38: begin
        period = 5'd24;
        tap    = TapR38[in_item_i.pos];
      end
      default: begin
        period = '0;
        tap    = '0;
      end
    endcase
    base      = 16'(in_item_i.blk) * 16'(period);
    s4_d.live = in_item_i.live;
    s4_d.k    = base[KW-1:0] + KW'(tap);
    s4_d.cost = in_item_i.cost;
  end

  // Items that were not mapped show position zero and no cost.
  always_comb begin
    logic ok;
    ok = s4_q.live && (s4_q.k != '0) && (s4_q.k <= KW'(mlen_i));
    if (!s4_q.live) begin
      s5_d.mother_position = '0;
    end else if (s4_q.k > KW'(PosMax)) begin
      s5_d.mother_position = PosMax;
    end else begin
      s5_d.mother_position = s4_q.k[PosW-1:0];
    end
    s5_d.in_range = ok;
    s5_d.cost_out = ok ? s4_q.cost : '0;
  end

  assign s5_ready    = !s5_valid_q || out_ready_i;
  assign s4_ready    = !s4_valid_q || s5_ready;
  assign in_ready_o  = s4_ready;
  assign out_valid_o = s5_valid_q;
  assign out_item_o  = s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_valid_q <= in_valid_i;
      end
      if (s5_ready) begin
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && in_valid_i) begin
      s4_q <= s4_d;
    end
    if (s5_ready && s4_valid_q) begin
      s5_q <= s5_d;
    end
  end

endmodule : rpm_map

`default_nettype wire

// ===== rtl/rcpc_puncture_position_mapper.sv =====
// ============================================================================
// RCPC puncture position mapper - top level
// Maps punctured coded-symbol indexes to rate-1/4 mother-code positions.
// ============================================================================
// The mapper accepts one item in every clock cycle unless an output stall has
// filled the pipeline. Its five stages are index check and stretch
// multiply, stretch add and block multiply, block and remainder split, tap
// lookup and position sum, and finally saturation and the range check against
// the mother length. Each stage holds its item while the stage after it is
// full, so a stall on the output only stops the input once every stage is
// occupied; bubbles are squeezed out on the way. The puncturer mode and the
// mother length are read live by the stages, so they should only be written
// while no item is in flight. Unused modes, a zero index and indexes beyond
// the largest index set by MaxIdx give position zero with the range flag clear.
// ============================================================================
`default_nettype none

module rcpc_puncture_position_mapper
  import rpm_pkg::*;
#(
  parameter int unsigned MaxIdx = MaxIndex
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input items.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_t                in_item_i,
  // Result items.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_t                    out_item_o,
  // Configuration writes.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [PosW-1:0]    cfg_data_i
);

  logic [ModeW-1:0] mode_q;
  logic [PosW-1:0]  mlen_q;

  logic s1_in_ready;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_item;
  logic s3_valid;
  logic s3_ready;
  s3_t  s3_item;

  // Registers are always writable; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeR23;
      mlen_q <= MotherLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegMode:      mode_q <= cfg_data_i[ModeW-1:0];
        RegMotherLen: mlen_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // The stall towards the source is simply the first stage being unable
  // to take a new item.
  assign in_stall_o = !s1_in_ready;

  rpm_stretch #(
    .MaxIdx (MaxIdx)
  ) u_stretch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_ready_o  (s1_in_ready),
    .out_valid_o (s1_valid),
    .out_item_o  (s1_item),
    .out_ready_i (s1_ready)
  );

  rpm_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (s1_valid),
    .in_item_i   (s1_item),
    .in_ready_o  (s1_ready),
    .out_valid_o (s3_valid),
    .out_item_o  (s3_item),
    .out_ready_i (s3_ready)
  );

  rpm_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .mlen_i      (mlen_q),
    .in_valid_i  (s3_valid),
    .in_item_i   (s3_item),
    .in_ready_o  (s3_ready),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_ready_i (!out_stall_i)
  );

endmodule : rcpc_puncture_position_mapper

`default_nettype wire

// ===== tb/sv/rpm_mapper_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Puncture position mapper checker
// Watches the item, result and register channels of the mapper, works out the
// expected mother position of every accepted item and compares it with the
// results in order.
// ----------------------------------------------------------------------------

module rpm_mapper_checker
  import rpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_t                in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_t               out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PosW-1:0]    cfg_data_i,
  input  logic               end_check_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 in_range_o,
  output int                 saturated_o
);

  localparam int unsigned StretchR292 = 65;
  localparam int unsigned StretchR148 = 35;
  localparam int          ReportLimit = 10;

  typedef struct {
    out_t              want;
    logic [IndexW-1:0] index;
  } mapping_t;

  // Tap offsets within one puncturing period, already shifted to 1-based.
  int unsigned taps_r23 [3]  = '{1, 2, 5};
  int unsigned taps_r13 [6]  = '{1, 2, 3, 5, 6, 7};
  int unsigned taps_r112 [3] = '{1, 2, 4};
  int unsigned taps_r72 [9]  = '{1, 2, 3, 4, 5, 7, 8, 10, 11};
  int unsigned taps_r38 [17] = '{1, 2, 3, 4, 5, 7, 8, 10, 11, 13, 14, 16, 17, 19, 20,
                                 22, 23};

  logic [ModeW-1:0] mode_q;
  logic [PosW-1:0]  mlen_q;
  mapping_t         mapping_q [$];
  bit               end_done;

  function automatic out_t map_symbol(input logic [ModeW-1:0] mode,
                                      input logic [PosW-1:0] mlen, input in_t sym);
    out_t        r;
    int unsigned j;
    int unsigned i;
    int unsigned span;
    int unsigned period;
    int unsigned stretch;
    int unsigned blk;
    int unsigned pos;
    int unsigned tap;
    int unsigned k;
    bit          known;
    r       = '0;
    j       = 32'(sym.coded_index);
    known   = 1'b1;
    stretch = 0;
    span    = 1;
    period  = 0;
    case (mode)
      ModeR23: begin
        span = 3; period = 8;
      end
      ModeR13: begin
        span = 6; period = 8;
      end
      ModeR292: begin
        span = 3; period = 8; stretch = StretchR292;
      end
      ModeR148: begin
        span = 6; period = 8; stretch = StretchR148;
      end
      ModeR112: begin
        span = 3; period = 6;
      end
      ModeR72: begin
        span = 9; period = 12;
      end
      ModeR38: begin
        span = 17; period = 24;
      end
      default: known = 1'b0;
    endcase
    if (!known || j == 0 || j > MaxIndex) return r;
    i   = (stretch != 0) ? j + (j - 1) / stretch : j;
    blk = (i - 1) / span;
    pos = (i - 1) % span;
    case (mode)
      ModeR23, ModeR292: tap = taps_r23[pos];
      ModeR13, ModeR148: tap = taps_r13[pos];
      ModeR112:          tap = taps_r112[pos];
      ModeR72:           tap = taps_r72[pos];
      default:           tap = taps_r38[pos];
    endcase
    k = period * blk + tap;
    // The range flag is judged on the unsaturated position.
    r.in_range        = (k >= 1 && k <= mlen);
    r.mother_position = (k > PosMax) ? PosMax : PosW'(k);
    r.cost_out        = r.in_range ? sym.soft_cost : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mapping_t m;
    out_t     got;
    if (!rst_ni) begin
      mapping_q.delete();
      mode_q       = ModeR23;
      mlen_q       = MotherLenReset;
      fail_count_o = 0;
      checked_o    = 0;
      in_range_o   = 0;
      saturated_o  = 0;
      end_done     = 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegMode:      mode_q = cfg_data_i[ModeW-1:0];
          RegMotherLen: mlen_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        m.want  = map_symbol(mode_q, mlen_q, in_item_i);
        m.index = in_item_i.coded_index;
        mapping_q.push_back(m);
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_item_i;
        if (mapping_q.size() == 0) begin
          if (fail_count_o < ReportLimit)
            $display("%0t: result with nothing expected: pos %0d range %0b cost %04h",
                     $time, got.mother_position, got.in_range, got.cost_out);
          fail_count_o++;
        end else begin
          m = mapping_q.pop_front();
          checked_o++;
          if (got.in_range === 1'b1) in_range_o++;
          if (got.mother_position === PosMax) saturated_o++;
          if (got.mother_position !== m.want.mother_position ||
              got.in_range !== m.want.in_range || got.cost_out !== m.want.cost_out) begin
            if (fail_count_o < ReportLimit) begin
              $display("%0t: index %0d expected pos %0d range %0b cost %04h",
                       $time, m.index, m.want.mother_position, m.want.in_range,
                       m.want.cost_out);
              $display("%0t: index %0d got pos %0d range %0b cost %04h",
                       $time, m.index, got.mother_position, got.in_range, got.cost_out);
            end
            fail_count_o++;
          end
        end
      end
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (mapping_q.size() != 0) begin
          $display("%0t: %0d results never arrived", $time, mapping_q.size());
          fail_count_o += mapping_q.size();
        end
      end
    end
    pending_o = mapping_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Puncture position mapper testbench
// Drives coded-symbol items and register writes into the mapper, with random
// gaps on the input and random stalls on the output, while a checker beside
// the block predicts every result and compares it.
// ----------------------------------------------------------------------------

module tb_top
  import rpm_pkg::*;
();

  // The register interface decodes two index bits, so two indexes exist that
  // address no register; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpareA  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB  = 2'd3;
  // Mode code that selects no puncturer.
  localparam logic [ModeW-1:0]   ModeUnused = 3'd7;
  localparam int                 PhaseCount = 16;
  localparam int                 PhaseItems = 80;
  // Phases from this one on run without gaps or stalls.
  localparam int                 CalmPhase  = 14;
  // The pipeline is five stages deep; a few spare cycles cover it.
  localparam int                 SettleCycles = 10;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = RegMode;
  logic [PosW-1:0]    cfg_data = '0;
  logic               end_check = 1'b0;

  int fail_count;
  int pending;
  int checked;
  int in_range_count;
  int saturated_count;

  // Idling is switched off for the closing phases.
  bit idle_on = 1'b1;
  int stall_left = 0;
  int settings_used = 0;

  always #5 clk = ~clk;

  rcpc_puncture_position_mapper uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  rpm_mapper_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .end_check_i (end_check),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .in_range_o  (in_range_count),
    .saturated_o (saturated_count)
  );

  // The result side holds off in bursts drawn at random. Once a burst has
  // begun it runs to its end, so stalls land on every pipeline phase.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 15) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high into the next item unless a gap burst is drawn here.
  task automatic send_symbol(input logic [IndexW-1:0] idx, input logic [CostW-1:0] cost);
    in_item  <= {idx, cost};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Registers may only change with the pipeline empty, so the sender stops
  // and waits until every expected result has come back before writing.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The upper data bits are random on a mode write; only the low three count.
  task automatic apply_setting(input logic [ModeW-1:0] mode, input logic [PosW-1:0] len,
                               input bit spare);
    logic [PosW-1:0] mode_word;
    drain();
    mode_word = {10'($urandom), mode};
    if ($urandom_range(0, 1) == 0) begin
      write_reg(RegMode, mode_word);
      write_reg(RegMotherLen, len);
    end else begin
      write_reg(RegMotherLen, len);
      write_reg(RegMode, mode_word);
    end
    if (spare) begin
      write_reg(RegSpareA, PosW'($urandom));
      write_reg(RegSpareB, PosW'($urandom));
    end
    settings_used++;
  endtask

  // Most indexes fall low enough that positions land near the mother length;
  // the rest spread over the full field with the zero index and the top index
  // drawn on purpose.
  function automatic logic [IndexW-1:0] pick_index();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return IndexW'(MaxIndex);
    if (sel < 8) return IndexW'($urandom_range(1, 64));
    if (sel < 14) return IndexW'($urandom_range(1, 700));
    return IndexW'($urandom_range(0, MaxIndex));
  endfunction

  function automatic logic [CostW-1:0] pick_cost();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return CostW'($urandom);
  endfunction

  initial begin
    logic [ModeW-1:0] mode;
    logic [PosW-1:0]  len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset setting: 2/3 puncturer, length 432.
    // The top index overflows the position range and saturates, the zero
    // index maps to nothing, and indexes 162 and 163 straddle the length.
    send_symbol(12'd1, 16'h0000);
    send_symbol(IndexW'(MaxIndex), 16'hFFFF);
    send_symbol(12'd0, 16'h1234);
    send_symbol(12'd162, 16'h5A5A);
    send_symbol(12'd163, 16'hA5A5);

    // Every other puncturer and the unused code, with the first and the last
    // index, and the stretch boundaries of the two stretched modes.
    for (int m = 1; m < 8; m++) begin
      mode = ModeW'(m);
      apply_setting(mode, PosMax, 1'b0);
      send_symbol(12'd1, 16'hFFFF);
      send_symbol(IndexW'(MaxIndex), pick_cost());
      if (mode == ModeR292) send_symbol(12'd66, 16'h8001);
      if (mode == ModeR148) send_symbol(12'd36, 16'h7FFE);
    end

    // Random phases. Each phase settles a new register setting; the length
    // is driven to zero and to its maximum in two of them.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph < 7) mode = ModeW'(ph);
      else if ($urandom_range(0, 9) == 0) mode = ModeUnused;
      else mode = ModeW'($urandom_range(0, 6));
      if (ph == 3) len = '0;
      else if (ph == 5) len = PosMax;
      else if ($urandom_range(0, 2) == 0) len = PosW'($urandom_range(0, PosMax));
      else len = PosW'($urandom_range(100, 1500));
      apply_setting(mode, len, ph % 4 == 1);
      idle_on = (ph < CalmPhase);
      for (int n = 0; n < PhaseItems; n++) send_symbol(pick_index(), pick_cost());
    end

    drain();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Checked %0d results over %0d settings, all puncturers and the unused code.",
             checked, settings_used);
    $display("%0d results fell inside the mother length and %0d saturated.",
             in_range_count, saturated_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run, where every item meets the longest gap
  // and the longest stall.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
